/* hw/rtl/xtea_block_cipher_macros.svh */
// Assertion macros for the XTEA block cipher RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XTEA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define XTEA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/xtea_pkg.sv */
// Shared types, constants and the round mixing function for the XTEA cipher.
// No dependencies; imported by every XTEA RTL module.
package xtea_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type key_type [KEY_WORDS];

   // Golden-ratio step of the running sum and the shift that picks the odd round key.
   localparam word_type XT_DELTA = 32'h9E37_79B9;
   localparam int unsigned XT_KEY_SHIFT = 11;

   // Direction codes.
   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 2'd3;

   // One block in flight through the chain.
   typedef struct packed {
      logic     action;
      word_type first;
      word_type second;
   } slot_type;

   // One finished block.
   typedef struct packed {
      word_type first;
      word_type second;
   } result_type;

   // Occupancy of the output buffer.
   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

   function automatic word_type xt_mix(input word_type v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

/* hw/rtl/xtea_cell.sv */
// One half-round cell of the XTEA chain: updates one block word per stage.
// Depends on xtea_pkg; instantiated in a row by xtea_block_cipher.
module xtea_cell
   import xtea_pkg::*;
#(
   parameter int unsigned CYCLES = 32,
   parameter int unsigned STAGE  = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  key_type  key,
   input  logic     in_valid,
   input  slot_type in_slot,
   output logic     out_valid,
   output slot_type out_slot
);

   localparam int unsigned ROUND = STAGE / 2;
   localparam bit          EVEN  = (STAGE % 2) == 0;

   // Sums seen by this half-round, fixed per stage for each direction.
   localparam int unsigned ENC_MULT = EVEN ? ROUND : ROUND + 1;
   localparam int unsigned DEC_MULT = EVEN ? CYCLES - ROUND : CYCLES - ROUND - 1;
   localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(XT_DELTA);
   localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(XT_DELTA);
   localparam word_type    ENC_SUM  = ENC_PROD[WORD_W-1:0];
   localparam word_type    DEC_SUM  = DEC_PROD[WORD_W-1:0];
   localparam logic [1:0]  ENC_IDX  = EVEN ? ENC_SUM[1:0] : 2'(ENC_SUM >> XT_KEY_SHIFT);
   localparam logic [1:0]  DEC_IDX  = EVEN ? 2'(DEC_SUM >> XT_KEY_SHIFT) : DEC_SUM[1:0];

   logic     valid_ff;
   slot_type slot_ff;
   slot_type slot_in;
   logic     upd_first;
   word_type src_word;
   word_type dst_word;
   word_type sum_key;
   word_type feistel;
   word_type new_word;

   always_comb begin
      // Encrypt touches the first word on even stages; decrypt runs mirrored.
      upd_first = (in_slot.action == ACTION_ENCRYPT) == EVEN;
      src_word  = upd_first ? in_slot.second : in_slot.first;
      dst_word  = upd_first ? in_slot.first : in_slot.second;
      sum_key   = (in_slot.action == ACTION_DECRYPT) ? DEC_SUM + key[DEC_IDX]
                                                     : ENC_SUM + key[ENC_IDX];
      feistel   = xt_mix(src_word) ^ sum_key;
      new_word  = (in_slot.action == ACTION_DECRYPT) ? dst_word - feistel
                                                     : dst_word + feistel;
      slot_in        = in_slot;
      if (upd_first) begin
         slot_in.first = new_word;
      end else begin
         slot_in.second = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slot  = slot_ff;

endmodule

/* hw/rtl/xtea_out_buf.sv */
// Two-entry output buffer (output register plus skid register) for the XTEA chain.
// Depends on xtea_pkg; instantiated by xtea_block_cipher.
module xtea_out_buf
   import xtea_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  result_type     push_data,
   input  logic           pop_ready,
   output result_type     out_data,
   output buf_status_type status
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       pop;
   logic       push;

   always_comb begin
      pop           = out_valid_ff && pop_ready;
      push          = push_valid && !skid_valid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Drain the skid entry into the output register.
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_data          = out_data_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

/* hw/rtl/xtea_block_cipher.sv */
// XTEA block cipher top level: key registers, chain of half-round cells, output buffer.
// Depends on xtea_pkg, xtea_cell, xtea_out_buf and xtea_block_cipher_macros.svh.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_action, req_block_first, req_block_second
//   rsp      out        rsp_valid/rsp_ready    rsp_result_first, rsp_result_second
//   csr      in         csr_write_en           csr_index, csr_write_data
//
// One transaction enters per cycle while req_ready is high; an accepted block passes
// through the row of 2*CYCLES half-round cells and then the output register, which
// drives rsp_valid.
// Synchronous active-high reset empties the cells and the output buffer and clears the key.
// A stalled result sits in the output register while the chain keeps moving; the second
// result lands in the skid register, and only then does the whole chain and req_ready hold.
`include "xtea_block_cipher_macros.svh"

module xtea_block_cipher
   import xtea_pkg::*;
#(
   parameter int unsigned CYCLES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [WORD_W-1:0]      req_block_first,
   input  logic [WORD_W-1:0]      req_block_second,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_result_first,
   output logic [WORD_W-1:0]      rsp_result_second,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_write_data
);

   // Two half-rounds per cycle of the cipher, one cell each.
   localparam int unsigned STAGES = 2 * CYCLES;

   key_type        key_ff;
   logic           advance;
   logic           chain_valid [STAGES+1];
   slot_type       chain_slot  [STAGES+1];
   result_type     tail_result;
   result_type     out_result;
   buf_status_type buf_status;

   // Key registers: user must write them only while idle, so no hazard with blocks in flight; not enforced here.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_WORD_0: key_ff[0] <= csr_write_data;
            CSR_KEY_WORD_1: key_ff[1] <= csr_write_data;
            CSR_KEY_WORD_2: key_ff[2] <= csr_write_data;
            CSR_KEY_WORD_3: key_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Advance the whole chain unless the skid register is occupied.
   assign advance   = !buf_status.skid_valid;
   assign req_ready = advance;

   assign chain_valid[0]       = req_valid;
   assign chain_slot[0].action = req_action;
   assign chain_slot[0].first  = req_block_first;
   assign chain_slot[0].second = req_block_second;

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      xtea_cell #(
         .CYCLES (CYCLES),
         .STAGE  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key       (key_ff),
         .in_valid  (chain_valid[g]),
         .in_slot   (chain_slot[g]),
         .out_valid (chain_valid[g+1]),
         .out_slot  (chain_slot[g+1])
      );
   end

   // Drop the direction flag at the end of the chain.
   assign tail_result.first  = chain_slot[STAGES].first;
   assign tail_result.second = chain_slot[STAGES].second;

   xtea_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (chain_valid[STAGES]),
      .push_data  (tail_result),
      .pop_ready  (rsp_ready),
      .out_data   (out_result),
      .status     (buf_status)
   );

   assign rsp_valid         = buf_status.out_valid;
   assign rsp_result_first  = out_result.first;
   assign rsp_result_second = out_result.second;

   `XTEA_ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_valid && req_ready, chain_valid[0] || g_cell[0].u_cell.out_valid, "accepted transaction did not enter the first cell")
   `XTEA_ASSERT_IMPLY(a_skid_needs_out, clock, reset, buf_status.skid_valid, buf_status.out_valid, "skid register holds data while output register is empty")
   `XTEA_ASSERT_NEXT(a_skid_holds, clock, reset, buf_status.skid_valid && !rsp_ready, buf_status.skid_valid, "skid entry lost without a pop")
   `XTEA_ASSERT_NEXT(a_tail_held_on_stall, clock, reset, chain_valid[STAGES] && !req_ready, chain_valid[STAGES], "tail cell dropped a block during a stall")

endmodule
